// ===== sv/bsr_pkg.sv =====
// Shared types, constants and helpers of the banker safety and request core.
// Used by bsr_alu, bsr_ctrl and banker_safety_and_request_core; no dependencies.
package bsr_pkg;

    localparam int NUM_PROC = 8;
    localparam int NUM_RES  = 4;
    localparam int PROC_W   = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
    localparam int RES_W    = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;

    localparam int CLAIM_W  = 8;
    localparam int CNT_W    = 10;
    localparam int OPND_W   = CNT_W + 2;
    localparam int PIDX_W   = 4;
    localparam int RIDX_W   = 3;
    localparam int SEQ_W    = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef logic signed [OPND_W-1:0] opnd_t;

    typedef enum logic [2:0] {
        MODE_LOAD_MAX   = 3'd0,
        MODE_LOAD_ALLOC = 3'd1,
        MODE_SET_AVAIL  = 3'd2,
        MODE_REQUEST    = 3'd3,
        MODE_SAFETY     = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        ST_LOADED      = 4'd0,
        ST_EXCEEDS     = 4'd1,
        ST_WAIT        = 4'd2,
        ST_GRANTED     = 4'd3,
        ST_RELEASED    = 4'd4,
        ST_SEQ_ENTRY   = 4'd5,
        ST_SAFE        = 4'd6,
        ST_UNSAFE      = 4'd7,
        ST_BAD_PROC    = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        ALU_SUB    = 2'd0,
        ALU_GT     = 2'd1,
        ALU_SATADD = 2'd2
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT,
        S_SAFE_CHECK,
        S_SAFE_NEED,
        S_SAFE_CMP,
        S_SAFE_ADD,
        S_SAFE_EMIT,
        S_VERDICT,
        S_REQ_NEED,
        S_REQ_CMP,
        S_REQ_AVAIL,
        S_REQ_TAKE,
        S_REQ_ALLOC,
        S_REQ_ZERO,
        S_REQ_RELEASE,
        S_REQ_DONE
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic [PIDX_W-1:0]  proc_index;
        logic [RIDX_W-1:0]  res_index;
        logic [CLAIM_W-1:0] amount;
        logic               last_element;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [SEQ_W-1:0]   seq_proc;
        logic               last_result;
    } result_t;

    typedef struct packed {
        alu_op_t op;
        opnd_t   a;
        opnd_t   b;
    } alu_req_t;

    typedef struct packed {
        opnd_t y;
        logic  gt;
    } alu_rsp_t;

    function automatic opnd_t ext_cnt(input logic [CNT_W-1:0] v);
        ext_cnt = opnd_t'({2'b00, v});
    endfunction

    function automatic opnd_t ext_claim(input logic [CLAIM_W-1:0] v);
        ext_claim = opnd_t'({{(OPND_W-CLAIM_W){1'b0}}, v});
    endfunction

endpackage

// ===== sv/banker_safety_and_request_core.sv =====
// Banker's algorithm allocator: safety check and request evaluation.
// A load or set result passes decode and emit; ready returns as the output register takes it.
// A final request element is checked against need and availability, then granted or released.
// A safety check runs on the single shared ALU, which does one subtract, compare or add per cycle;
// it pauses while a sequence entry waits for the output register.
// Reset (rst_n low, asynchronous) clears every table, the request buffer and the output valid flag.
module banker_safety_and_request_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] proc_index, [6:4] res_index, [14:7] amount, [15] 0
    input  logic [2:0]  s_axis_tuser,   // [2:0] mode
    input  logic        s_axis_tlast,   // last_element

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] seq_proc, [7:4] 0
    output logic [3:0]  m_axis_tuser,   // [3:0] status
    output logic        m_axis_tlast    // last_result
);

    bsr_pkg::item_t   item;
    bsr_pkg::result_t res;
    logic             res_valid;
    logic             res_ready;

    logic             out_valid_reg, out_valid_next;
    bsr_pkg::result_t out_reg, out_next;

    // Unpack the input transaction into the item fields.
    assign item.mode         = bsr_pkg::mode_t'(s_axis_tuser);
    assign item.proc_index   = s_axis_tdata[3:0];
    assign item.res_index    = s_axis_tdata[6:4];
    assign item.amount       = s_axis_tdata[14:7];
    assign item.last_element = s_axis_tlast;

    bsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register parts the sequencer from the sink: take a new result
    // when the register is empty or being drained in this cycle.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            // drop the delivered result
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload holds without reset; it is only seen while valid is high.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.seq_proc};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last_result;

endmodule

// ===== sv/bsr_alu.sv =====
// Shared arithmetic unit: subtract, signed greater-than and saturating add.
// Depends on bsr_pkg.
module bsr_alu
(
    input  bsr_pkg::alu_req_t req,
    output bsr_pkg::alu_rsp_t rsp
);

    bsr_pkg::opnd_t diff;
    bsr_pkg::opnd_t sum;

    assign diff = req.a - req.b;
    assign sum  = req.a + req.b;

    always_comb
    begin
        rsp.gt = (req.a > req.b);
        case (req.op)
            bsr_pkg::ALU_SUB:
            begin
                rsp.y = diff;
            end
            bsr_pkg::ALU_SATADD:
            begin
                // clamp at the top count
                if (sum > bsr_pkg::ext_cnt(bsr_pkg::COUNT_MAX))
                begin
                    rsp.y = bsr_pkg::ext_cnt(bsr_pkg::COUNT_MAX);
                end
                else
                begin
                    rsp.y = sum;
                end
            end
            default:
            begin
                rsp.y = diff;
            end
        endcase
    end

endmodule

// ===== sv/bsr_ctrl.sv =====
// Sequencer and state tables of the banker core; at most one ALU operation per cycle.
// Depends on bsr_pkg and bsr_alu.
module bsr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsr_pkg::item_t    item,
    output logic              res_valid,
    input  logic              res_ready,
    output bsr_pkg::result_t  res
);

    localparam int NP = bsr_pkg::NUM_PROC;
    localparam int NR = bsr_pkg::NUM_RES;
    localparam int PW = bsr_pkg::PROC_W;
    localparam int RW = bsr_pkg::RES_W;
    localparam int CW = bsr_pkg::CNT_W;
    localparam int MW = bsr_pkg::CLAIM_W;

    bsr_pkg::state_t  state_reg, state_next;
    bsr_pkg::item_t   item_reg, item_next;
    bsr_pkg::status_t status_reg, status_next;

    logic [MW-1:0] max_claim_reg [NP][NR];
    logic [MW-1:0] max_claim_next [NP][NR];
    logic [CW-1:0] alloc_reg [NP][NR];
    logic [CW-1:0] alloc_next [NP][NR];
    logic [CW-1:0] avail_reg [NR];
    logic [CW-1:0] avail_next [NR];
    logic [MW-1:0] reqbuf_reg [NR];
    logic [MW-1:0] reqbuf_next [NR];
    logic [CW-1:0] work_reg [NR];
    logic [CW-1:0] work_next [NR];
    logic [NP-1:0] finished_reg, finished_next;

    logic [PW-1:0]  p_reg, p_next;
    logic [RW-1:0]  r_reg, r_next;
    logic [PW-1:0]  pass_reg, pass_next;
    bsr_pkg::opnd_t need_reg, need_next;

    bsr_pkg::alu_req_t alu_req;
    bsr_pkg::alu_rsp_t alu_rsp;

    logic          pok;
    logic          rok;
    logic [PW-1:0] item_p;
    logic [RW-1:0] item_r;
    logic [MW-1:0] cur_max;
    logic [CW-1:0] cur_alloc;
    logic [CW-1:0] cur_avail;
    logic [MW-1:0] cur_req;
    logic [CW-1:0] cur_work;
    logic          r_last;
    logic          p_last;
    logic          pass_last;

    bsr_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign pok       = (int'(item_reg.proc_index) < NP);
    assign rok       = (int'(item_reg.res_index) < NR);
    assign item_p    = item_reg.proc_index[PW-1:0];
    assign item_r    = item_reg.res_index[RW-1:0];
    assign cur_max   = max_claim_reg[p_reg][r_reg];
    assign cur_alloc = alloc_reg[p_reg][r_reg];
    assign cur_avail = avail_reg[r_reg];
    assign cur_req   = reqbuf_reg[r_reg];
    assign cur_work  = work_reg[r_reg];
    assign r_last    = (r_reg == RW'(NR - 1));
    assign p_last    = (p_reg == PW'(NP - 1));
    assign pass_last = (pass_reg == PW'(NP - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bsr_pkg::S_IDLE;
            finished_reg <= '0;
            p_reg        <= '0;
            r_reg        <= '0;
            pass_reg     <= '0;
            for (int i = 0; i < NP; i++)
            begin
                for (int j = 0; j < NR; j++)
                begin
                    max_claim_reg[i][j] <= '0;
                    alloc_reg[i][j]     <= '0;
                end
            end
            for (int j = 0; j < NR; j++)
            begin
                avail_reg[j]  <= '0;
                reqbuf_reg[j] <= '0;
                work_reg[j]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            finished_reg  <= finished_next;
            p_reg         <= p_next;
            r_reg         <= r_next;
            pass_reg      <= pass_next;
            max_claim_reg <= max_claim_next;
            alloc_reg     <= alloc_next;
            avail_reg     <= avail_next;
            reqbuf_reg    <= reqbuf_next;
            work_reg      <= work_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        need_reg   <= need_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        need_next      = need_reg;
        finished_next  = finished_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        pass_next      = pass_reg;
        max_claim_next = max_claim_reg;
        alloc_next     = alloc_reg;
        avail_next     = avail_reg;
        reqbuf_next    = reqbuf_reg;
        work_next      = work_reg;

        alu_req.op = bsr_pkg::ALU_SUB;
        alu_req.a  = bsr_pkg::ext_claim(cur_max);
        alu_req.b  = bsr_pkg::ext_cnt(cur_alloc);

        in_ready        = 1'b0;
        res_valid       = 1'b0;
        res.status      = status_reg;
        res.seq_proc    = '0;
        res.last_result = 1'b1;

        case (state_reg)
            bsr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = item;
                    state_next = bsr_pkg::S_DECODE;
                end
            end

            bsr_pkg::S_DECODE:
            begin
                state_next  = bsr_pkg::S_EMIT;
                status_next = bsr_pkg::ST_LOADED;
                case (item_reg.mode)
                    bsr_pkg::MODE_LOAD_MAX:
                    begin
                        if (!pok)
                        begin
                            status_next = bsr_pkg::ST_BAD_PROC;
                        end
                        else if (rok)
                        begin
                            max_claim_next[item_p][item_r] = item_reg.amount;
                        end
                    end
                    bsr_pkg::MODE_LOAD_ALLOC:
                    begin
                        if (!pok)
                        begin
                            status_next = bsr_pkg::ST_BAD_PROC;
                        end
                        else if (rok)
                        begin
                            alloc_next[item_p][item_r] = CW'(item_reg.amount);
                        end
                    end
                    bsr_pkg::MODE_SET_AVAIL:
                    begin
                        if (rok)
                        begin
                            avail_next[item_r] = CW'(item_reg.amount);
                        end
                    end
                    bsr_pkg::MODE_REQUEST:
                    begin
                        if (!pok)
                        begin
                            status_next = bsr_pkg::ST_BAD_PROC;
                            if (item_reg.last_element)
                            begin
                                for (int j = 0; j < NR; j++)
                                begin
                                    reqbuf_next[j] = '0;
                                end
                            end
                        end
                        else
                        begin
                            if (rok)
                            begin
                                reqbuf_next[item_r] = item_reg.amount;
                            end
                            if (item_reg.last_element)
                            begin
                                p_next     = item_p;
                                r_next     = '0;
                                state_next = bsr_pkg::S_REQ_NEED;
                            end
                        end
                    end
                    bsr_pkg::MODE_SAFETY:
                    begin
                        work_next     = avail_reg;
                        finished_next = '0;
                        p_next        = '0;
                        r_next        = '0;
                        pass_next     = '0;
                        state_next    = bsr_pkg::S_SAFE_CHECK;
                    end
                    default:
                    begin
                        state_next = bsr_pkg::S_IDLE;
                    end
                endcase
            end

            bsr_pkg::S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bsr_pkg::S_IDLE;
                end
            end

            // ---- safety check: passes over rows, at most one ALU step a cycle ----
            bsr_pkg::S_SAFE_CHECK:
            begin
                r_next = '0;
                if (finished_reg[p_reg])
                begin
                    p_next = p_last ? '0 : p_reg + 1'b1;
                    if (p_last)
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = pass_last ? bsr_pkg::S_VERDICT : bsr_pkg::S_SAFE_CHECK;
                    end
                end
                else
                begin
                    state_next = bsr_pkg::S_SAFE_NEED;
                end
            end

            bsr_pkg::S_SAFE_NEED:
            begin
                need_next  = alu_rsp.y;
                state_next = bsr_pkg::S_SAFE_CMP;
            end

            bsr_pkg::S_SAFE_CMP:
            begin
                alu_req.op = bsr_pkg::ALU_GT;
                alu_req.a  = need_reg;
                alu_req.b  = bsr_pkg::ext_cnt(cur_work);
                if (alu_rsp.gt)
                begin
                    // row does not fit: move on to the next row
                    p_next = p_last ? '0 : p_reg + 1'b1;
                    if (p_last)
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = pass_last ? bsr_pkg::S_VERDICT : bsr_pkg::S_SAFE_CHECK;
                    end
                    else
                    begin
                        state_next = bsr_pkg::S_SAFE_CHECK;
                    end
                end
                else if (r_last)
                begin
                    r_next     = '0;
                    state_next = bsr_pkg::S_SAFE_ADD;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = bsr_pkg::S_SAFE_NEED;
                end
            end

            bsr_pkg::S_SAFE_ADD:
            begin
                alu_req.op        = bsr_pkg::ALU_SATADD;
                alu_req.a         = bsr_pkg::ext_cnt(cur_work);
                alu_req.b         = bsr_pkg::ext_cnt(cur_alloc);
                work_next[r_reg]  = alu_rsp.y[CW-1:0];
                r_next            = r_last ? '0 : r_reg + 1'b1;
                if (r_last)
                begin
                    state_next = bsr_pkg::S_SAFE_EMIT;
                end
            end

            bsr_pkg::S_SAFE_EMIT:
            begin
                res_valid       = 1'b1;
                res.status      = bsr_pkg::ST_SEQ_ENTRY;
                res.seq_proc    = bsr_pkg::SEQ_W'(p_reg);
                res.last_result = 1'b0;
                if (res_ready)
                begin
                    finished_next[p_reg] = 1'b1;
                    p_next = p_last ? '0 : p_reg + 1'b1;
                    if (p_last)
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = pass_last ? bsr_pkg::S_VERDICT : bsr_pkg::S_SAFE_CHECK;
                    end
                    else
                    begin
                        state_next = bsr_pkg::S_SAFE_CHECK;
                    end
                end
            end

            bsr_pkg::S_VERDICT:
            begin
                res_valid  = 1'b1;
                res.status = (&finished_reg) ? bsr_pkg::ST_SAFE : bsr_pkg::ST_UNSAFE;
                if (res_ready)
                begin
                    state_next = bsr_pkg::S_IDLE;
                end
            end

            // ---- request evaluation ----
            bsr_pkg::S_REQ_NEED:
            begin
                need_next  = alu_rsp.y;
                state_next = bsr_pkg::S_REQ_CMP;
            end

            bsr_pkg::S_REQ_CMP:
            begin
                alu_req.op = bsr_pkg::ALU_GT;
                alu_req.a  = bsr_pkg::ext_claim(cur_req);
                alu_req.b  = need_reg;
                if (alu_rsp.gt)
                begin
                    status_next = bsr_pkg::ST_EXCEEDS;
                    state_next  = bsr_pkg::S_REQ_DONE;
                end
                else
                begin
                    r_next     = r_last ? '0 : r_reg + 1'b1;
                    state_next = r_last ? bsr_pkg::S_REQ_AVAIL : bsr_pkg::S_REQ_NEED;
                end
            end

            bsr_pkg::S_REQ_AVAIL:
            begin
                alu_req.op = bsr_pkg::ALU_GT;
                alu_req.a  = bsr_pkg::ext_claim(cur_req);
                alu_req.b  = bsr_pkg::ext_cnt(cur_avail);
                if (alu_rsp.gt)
                begin
                    status_next = bsr_pkg::ST_WAIT;
                    state_next  = bsr_pkg::S_REQ_DONE;
                end
                else
                begin
                    r_next     = r_last ? '0 : r_reg + 1'b1;
                    state_next = r_last ? bsr_pkg::S_REQ_TAKE : bsr_pkg::S_REQ_AVAIL;
                end
            end

            bsr_pkg::S_REQ_TAKE:
            begin
                alu_req.op        = bsr_pkg::ALU_SUB;
                alu_req.a         = bsr_pkg::ext_cnt(cur_avail);
                alu_req.b         = bsr_pkg::ext_claim(cur_req);
                avail_next[r_reg] = alu_rsp.y[CW-1:0];
                state_next        = bsr_pkg::S_REQ_ALLOC;
            end

            bsr_pkg::S_REQ_ALLOC:
            begin
                alu_req.op               = bsr_pkg::ALU_SATADD;
                alu_req.a                = bsr_pkg::ext_cnt(cur_alloc);
                alu_req.b                = bsr_pkg::ext_claim(cur_req);
                alloc_next[p_reg][r_reg] = alu_rsp.y[CW-1:0];
                r_next                   = r_last ? '0 : r_reg + 1'b1;
                state_next               = r_last ? bsr_pkg::S_REQ_ZERO : bsr_pkg::S_REQ_TAKE;
            end

            bsr_pkg::S_REQ_ZERO:
            begin
                if (alu_rsp.y != '0)
                begin
                    status_next = bsr_pkg::ST_GRANTED;
                    state_next  = bsr_pkg::S_REQ_DONE;
                end
                else
                begin
                    r_next     = r_last ? '0 : r_reg + 1'b1;
                    state_next = r_last ? bsr_pkg::S_REQ_RELEASE : bsr_pkg::S_REQ_ZERO;
                end
            end

            bsr_pkg::S_REQ_RELEASE:
            begin
                alu_req.op               = bsr_pkg::ALU_SATADD;
                alu_req.a                = bsr_pkg::ext_cnt(cur_avail);
                alu_req.b                = bsr_pkg::ext_cnt(cur_alloc);
                avail_next[r_reg]        = alu_rsp.y[CW-1:0];
                alloc_next[p_reg][r_reg] = '0;
                r_next                   = r_last ? '0 : r_reg + 1'b1;
                if (r_last)
                begin
                    status_next = bsr_pkg::ST_RELEASED;
                    state_next  = bsr_pkg::S_REQ_DONE;
                end
            end

            bsr_pkg::S_REQ_DONE:
            begin
                for (int j = 0; j < NR; j++)
                begin
                    reqbuf_next[j] = '0;
                end
                state_next = bsr_pkg::S_EMIT;
            end

            default:
            begin
                state_next = bsr_pkg::S_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && res_valid))
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer ready right after a transaction");

    a_safe_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == bsr_pkg::ST_SAFE) |-> (&finished_reg))
        else $error("safe verdict with an unfinished process");

    a_seq_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsr_pkg::S_SAFE_EMIT) |-> !finished_reg[p_reg])
        else $error("process emitted twice in the safe sequence");

endmodule
